// ===== sv/longest_distinct_window_top_assert.svh =====
// assertion macros for the longest distinct window block
`ifndef LONGEST_DISTINCT_WINDOW_TOP_ASSERT_SVH
`define LONGEST_DISTINCT_WINDOW_TOP_ASSERT_SVH

// condition holds at every clock edge outside reset
`define LDW_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// trigger implies condition in the following cycle
`define LDW_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ===== sv/ldw_pkg.sv =====
// shared constants for the longest distinct window block
`default_nettype none

package ldw_pkg;

   localparam logic PRESENT = 1'b1;
   localparam logic ABSENT  = 1'b0;

endpackage

`default_nettype wire

// ===== sv/longest_distinct_window_top.sv =====
// longest repeat-free window over a value stream, one shared memory sequencer
// an accepted value goes through lookup and check, then a drop read and a drop write per evicted entry,
// then insert, which registers the result; a first flag also evicts the whole window before lookup
// one item at a time; insert waits while an earlier result is still held and not taken
// reset: synchronous; a clear pass over all 2^VALUE_BITS addresses (1024 by default) empties the
// count memory, req_ready stays low until it ends
`default_nettype none

module longest_distinct_window_top #(
   parameter int VALUE_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  req_first,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS:0]   rsp_window_length,
   output logic [VALUE_BITS:0]   rsp_best_length
);

   localparam int DEPTH    = 1 << VALUE_BITS;
   localparam int LEN_BITS = VALUE_BITS + 1;
   localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(DEPTH);
   localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_CHECK,
      ST_DROP_RD,
      ST_DROP_WR,
      ST_INSERT
   } state_type;

   state_type               state_ff, state_in;
   logic [VALUE_BITS-1:0]   clr_addr_ff, clr_addr_in;
   logic [VALUE_BITS-1:0]   val_ff, val_in;
   logic                    drain_ff, drain_in;
   logic [VALUE_BITS-1:0]   left_ff, left_in;
   logic [VALUE_BITS-1:0]   right_ff, right_in;
   logic [LEN_BITS-1:0]     len_ff, len_in;
   logic [LEN_BITS-1:0]     longest_ff, longest_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [LEN_BITS-1:0]     rsp_len_ff, rsp_len_in;
   logic [LEN_BITS-1:0]     rsp_best_ff, rsp_best_in;

   logic                    presence_mem [DEPTH];
   logic                    presence_q_ff;
   logic [VALUE_BITS-1:0]   ring_mem [DEPTH];
   logic [VALUE_BITS-1:0]   ring_q_ff;

   logic                    pres_we;
   logic [VALUE_BITS-1:0]   pres_waddr;
   logic                    pres_wdata;
   logic                    ring_we;
   logic [LEN_BITS-1:0]     len_new;

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_window_length = rsp_len_ff;
   assign rsp_best_length   = rsp_best_ff;
   assign len_new           = len_ff + LEN_ONE;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      val_in       = val_ff;
      drain_in     = drain_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      len_in       = len_ff;
      longest_in   = longest_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_len_in   = rsp_len_ff;
      rsp_best_in  = rsp_best_ff;
      pres_we      = 1'b0;
      pres_waddr   = val_ff;
      pres_wdata   = ldw_pkg::ABSENT;
      ring_we      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            pres_we     = 1'b1;
            pres_waddr  = clr_addr_ff;
            clr_addr_in = clr_addr_ff + VALUE_BITS'(1);
            if (&clr_addr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               val_in   = req_value;
               drain_in = req_first && (len_ff != '0);
               if (req_first) begin
                  longest_in = '0;
               end
               state_in = (req_first && (len_ff != '0)) ? ST_DROP_RD : ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if ((presence_q_ff == ldw_pkg::PRESENT) && (len_ff != '0)) begin
               state_in = ST_DROP_RD;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_DROP_RD: begin
            state_in = ST_DROP_WR;
         end
         ST_DROP_WR: begin
            pres_we    = 1'b1;
            pres_waddr = ring_q_ff;
            pres_wdata = ldw_pkg::ABSENT;
            left_in    = left_ff + VALUE_BITS'(1);
            len_in     = len_ff - LEN_ONE;
            if (drain_ff) begin
               if (len_ff == LEN_ONE) begin
                  drain_in = 1'b0;
                  state_in = ST_LOOKUP;
               end else begin
                  state_in = ST_DROP_RD;
               end
            end else if (ring_q_ff == val_ff) begin
               state_in = ST_INSERT;
            end else begin
               state_in = ST_DROP_RD;
            end
         end
         ST_INSERT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               pres_we      = 1'b1;
               pres_waddr   = val_ff;
               pres_wdata   = ldw_pkg::PRESENT;
               ring_we      = 1'b1;
               right_in     = right_ff + VALUE_BITS'(1);
               len_in       = len_new;
               longest_in   = (len_new > longest_ff) ? len_new : longest_ff;
               rsp_valid_in = 1'b1;
               rsp_len_in   = len_new;
               rsp_best_in  = (len_new > longest_ff) ? len_new : longest_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         drain_ff     <= 1'b0;
         left_ff      <= '0;
         right_ff     <= '0;
         len_ff       <= '0;
         longest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         drain_ff     <= drain_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         len_ff       <= len_in;
         longest_ff   <= longest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      val_ff      <= val_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_best_ff <= rsp_best_in;
   end

   // count memory, one presence bit per value
   always_ff @(posedge clock) begin
      if (pres_we) begin
         presence_mem[pres_waddr] <= pres_wdata;
      end
      presence_q_ff <= presence_mem[val_ff];
   end

   // ring of window values
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[right_ff] <= val_ff;
      end
      ring_q_ff <= ring_mem[left_ff];
   end

`include "longest_distinct_window_top_assert.svh"

   `LDW_ASSERT_NOW(a_best_covers_window, !rsp_valid_ff || (rsp_best_ff >= rsp_len_ff), "best below window length")
   `LDW_ASSERT_NOW(a_len_bound, len_ff <= LEN_MAX, "window longer than ring")
   `LDW_ASSERT_NOW(a_drop_nonempty, (state_ff != ST_DROP_WR) || (len_ff != '0), "eviction from empty window")
   `LDW_ASSERT_NOW(a_ring_span, VALUE_BITS'(right_ff - left_ff) == len_ff[VALUE_BITS-1:0], "ring pointers disagree with length")
   `LDW_ASSERT_NEXT(a_insert_delivers, (state_ff == ST_INSERT) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && (rsp_len_ff == len_ff), "insert without result transfer")

endmodule

`default_nettype wire
